// File: sv/go_to_goal_steering_defines.svh
// Assertion macros for the steering block checker.
`ifndef GO_TO_GOAL_STEERING_DEFINES_SVH
`define GO_TO_GOAL_STEERING_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GTG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GTG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/gtg_pkg.sv
// Shared constants, types and tables for the go-to-goal steering block.
package gtg_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ZW = 20;   // CORDIC angle width, Q.16
  localparam int XW = 33;   // CORDIC vector width
  localparam logic signed [ZW-1:0] PI16 = 20'sd205887;
  localparam logic signed [ZW:0] TWO_PI16 = 21'sd411775;
  localparam logic signed [15:0] SIXTH_PI13 = 16'sd4289;
  localparam logic [15:0] INV_GAIN16 = 16'd39797;
  localparam int PRE_SHIFT = 14;

  typedef enum logic [2:0] {
    REG_GOAL_X = 3'd0,
    REG_GOAL_Y = 3'd1,
    REG_ARRIVE = 3'd2,
    REG_SPEED_GAIN = 3'd3,
    REG_TURN_GAIN = 3'd4,
    REG_SPEED_LIMIT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [14:0] arrive_distance;
    logic [15:0] speed_gain;
    logic [15:0] turn_gain;
    logic [14:0] speed_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0] head;
    logic zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] t [ATAN_ENTRIES];
    t = '{20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
          20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
          20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
          20'sd0, 20'sd0, 20'sd0};
    return t[i];
  endfunction
endpackage

// File: sv/gtg_cordic_stage.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
module gtg_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  gtg_pkg::cordic_t in_data,
  output logic out_valid,
  output gtg_pkg::cordic_t out_data
);
  gtg_pkg::cordic_t nxt;
  always_comb begin
    logic signed [gtg_pkg::XW-1:0] xs, ys;
    xs = in_data.x >>> SHIFT;
    ys = in_data.y >>> SHIFT;
    nxt = in_data;
    if (!in_data.y[gtg_pkg::XW-1]) begin
      nxt.x = in_data.x + ys;
      nxt.y = in_data.y - xs;
      nxt.z = in_data.z + gtg_pkg::atan_q16(SHIFT);
    end else begin
      nxt.x = in_data.x - ys;
      nxt.y = in_data.y + xs;
      nxt.z = in_data.z - gtg_pkg::atan_q16(SHIFT);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

// File: sv/gtg_cordic.sv
// Pipelined CORDIC in vectoring mode with entry pre-rotation.
module gtg_cordic #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  input  logic signed [15:0] head,
  output logic out_valid,
  output gtg_pkg::cordic_t out_data
);
  gtg_pkg::cordic_t d [CORDIC_STEPS+1];
  logic v [CORDIC_STEPS+1];
  gtg_pkg::cordic_t pre;
  always_comb begin
    logic signed [gtg_pkg::XW-1:0] x0, y0;
    x0 = gtg_pkg::XW'(dx) <<< gtg_pkg::PRE_SHIFT;
    y0 = gtg_pkg::XW'(dy) <<< gtg_pkg::PRE_SHIFT;
    pre.head = head;
    pre.zero = (dx == '0) && (dy == '0);
    pre.z = '0;
    pre.x = x0;
    pre.y = y0;
    if (dx[16]) begin
      pre.z = dy[16] ? -gtg_pkg::PI16 : gtg_pkg::PI16;
      pre.x = -x0;
      pre.y = -y0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      d[0] <= pre;
    end
  end
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    gtg_cordic_stage #(.SHIFT(i)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i]), .in_data(d[i]),
      .out_valid(v[i+1]), .out_data(d[i+1])
    );
  end
  assign out_valid = v[CORDIC_STEPS];
  assign out_data = d[CORDIC_STEPS];
endmodule

// File: sv/gtg_command.sv
// Scaling, angle wrap and command selection behind the CORDIC.
module gtg_command (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  gtg_pkg::cfg_t cfg,
  input  logic in_valid,
  input  gtg_pkg::cordic_t in_data,
  output logic out_valid,
  output logic status,
  output logic signed [15:0] linear_speed,
  output logic signed [15:0] turn_rate
);
  // stage A: magnitude product and raw heading error
  logic va, zero_a;
  logic [48:0] prod_a;
  logic signed [gtg_pkg::ZW+1:0] alpha_a;
  // stage B: rounded distance, wrapped Q3.13 error
  logic vb;
  logic [18:0] r_b;
  logic signed [16:0] al_b;
  // stage C: gain products
  logic vc, reach_c, big_c;
  logic [34:0] sp_c;
  logic signed [33:0] tr_c;
  logic signed [16:0] al_c;
  logic [14:0] lim_c;

  logic [gtg_pkg::XW-2:0] xmag;
  assign xmag = in_data.x[gtg_pkg::XW-1] ? '0 : in_data.x[gtg_pkg::XW-2:0];

  logic signed [gtg_pkg::ZW+1:0] wr;
  logic signed [gtg_pkg::ZW+1:0] rnd;
  always_comb begin
    wr = alpha_a;
    if (alpha_a > (gtg_pkg::ZW+2)'(gtg_pkg::PI16)) begin
      wr = alpha_a - (gtg_pkg::ZW+2)'(gtg_pkg::TWO_PI16);
    end else if (alpha_a < -(gtg_pkg::ZW+2)'(gtg_pkg::PI16)) begin
      wr = alpha_a + (gtg_pkg::ZW+2)'(gtg_pkg::TWO_PI16);
    end
    rnd = (wr + 22'sd4) >>> 3;
  end

  logic [18:0] r_full;
  assign r_full = zero_a ? '0 : 19'((prod_a + 49'(1 << 29)) >> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
    if (en) begin
      prod_a <= 49'(xmag) * 49'(gtg_pkg::INV_GAIN16);
      zero_a <= in_data.zero;
      alpha_a <= (in_data.zero ? 22'sd0 : 22'(in_data.z))
                 - (22'(in_data.head) <<< 3);
      r_b <= r_full;
      al_b <= 17'(rnd);
      reach_c <= r_b < 19'(cfg.arrive_distance);
      big_c <= (al_b > 17'(gtg_pkg::SIXTH_PI13)) || (al_b < -17'(gtg_pkg::SIXTH_PI13));
      sp_c <= 35'(cfg.speed_gain) * 35'(r_b) + 35'd128;
      tr_c <= $signed({1'b0, cfg.turn_gain}) * 34'(al_b) + 34'sd128;
      al_c <= al_b;
      lim_c <= cfg.speed_limit;
      if (reach_c) begin
        status <= 1'b1;
        linear_speed <= '0;
        turn_rate <= '0;
      end else if (big_c) begin
        status <= 1'b0;
        linear_speed <= '0;
        turn_rate <= al_c[16] ? -gtg_pkg::SIXTH_PI13 : gtg_pkg::SIXTH_PI13;
      end else begin
        status <= 1'b0;
        linear_speed <= ((sp_c >> 8) > 35'(lim_c)) ? 16'(lim_c) : 16'(sp_c >> 8);
        if ((tr_c >>> 8) > 34'sd32767) begin
          turn_rate <= 16'sh7fff;
        end else if ((tr_c >>> 8) < -34'sd32768) begin
          turn_rate <= 16'sh8000;
        end else begin
          turn_rate <= 16'(tr_c >>> 8);
        end
      end
    end
  end
endmodule

// File: sv/go_to_goal_steering.sv
// Top level of the go-to-goal steering block.
// Fully pipelined: one pose word accepted per clock while the output is not stalled; the stages
// are the input register, pre-rotation, one CORDIC stage per step and four scaling/command stages.
// The whole pipeline advances together and holds when the result at the output is not
// taken. The goal registers are applied as a word enters, the other registers at the
// command stages, so write configuration only while no word is in flight.
module go_to_goal_steering #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,   // pose_x, pose_y, pose_heading
  output logic m_tvalid,
  input  logic m_tready,
  output logic [39:0] m_tdata,   // status, linear_speed, turn_rate, 7'b0
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  gtg_pkg::cfg_t cfg;
  logic en, v0, cv, status;
  logic signed [16:0] dx, dy;
  logic signed [15:0] head, lin, turn;
  gtg_pkg::cordic_t cd;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_x <= '0;
      cfg.goal_y <= '0;
      cfg.arrive_distance <= 15'd26;
      cfg.speed_gain <= 16'd256;
      cfg.turn_gain <= 16'd256;
      cfg.speed_limit <= 15'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gtg_pkg::REG_GOAL_X: cfg.goal_x <= cfg_data;
        gtg_pkg::REG_GOAL_Y: cfg.goal_y <= cfg_data;
        gtg_pkg::REG_ARRIVE: cfg.arrive_distance <= cfg_data[14:0];
        gtg_pkg::REG_SPEED_GAIN: cfg.speed_gain <= cfg_data;
        gtg_pkg::REG_TURN_GAIN: cfg.turn_gain <= cfg_data;
        gtg_pkg::REG_SPEED_LIMIT: cfg.speed_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      dx <= 17'(cfg.goal_x) - 17'($signed(s_tdata[15:0]));
      dy <= 17'(cfg.goal_y) - 17'($signed(s_tdata[31:16]));
      head <= s_tdata[47:32];
    end
  end

  gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0),
    .dx(dx), .dy(dy), .head(head), .out_valid(cv), .out_data(cd)
  );

  gtg_command u_cmd (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg), .in_valid(cv), .in_data(cd),
    .out_valid(m_tvalid), .status(status), .linear_speed(lin), .turn_rate(turn)
  );

  assign m_tdata = {7'b0, turn, lin, status};
endmodule

// File: sv/gtg_checker.sv
// Port-level checker for the steering block, bound to the top level.
`include "go_to_goal_steering_defines.svh"
module gtg_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [39:0] m_tdata
);
  `GTG_ASSERT_IMP(a_reached_zero, clk, rst, m_tvalid && m_tdata[0], m_tdata[32:1] == 32'd0, "reached word carries nonzero command")
  `GTG_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[39:33] == 7'd0, "pad bits set")
  `GTG_ASSERT_IMP(a_ready_follows, clk, rst, !m_tvalid || m_tready, s_tready, "input stalled with output free")
  `GTG_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule

bind go_to_goal_steering gtg_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: tb/go_to_goal_steering_check.sv
// Checker for the go-to-goal steering block: tracks registers, predicts and compares results.
`timescale 1ns / 1ps
module go_to_goal_steering_check #(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fails
);
  import gtg_pkg::*;

  typedef struct packed {
    logic              status;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
  } command_t;

  command_t cmd_q[$];

  logic signed [15:0] goal_x, goal_y;
  logic [14:0] arrive, speed_lim;
  logic [15:0] speed_k, turn_k;

  function automatic command_t steer(input logic [47:0] w);
    longint ang_tab [24];
    longint dx, dy, head, x, y, z, xs, ys, r, alpha, v, rot;
    command_t c;
    ang_tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32,
                16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    dx = longint'(goal_x) - longint'($signed(w[15:0]));
    dy = longint'(goal_y) - longint'($signed(w[31:16]));
    head = longint'($signed(w[47:32]));
    c = '0;
    if (dx == 0 && dy == 0) begin
      r = 0;
      z = 0;
    end else begin
      x = dx <<< PRE_SHIFT;
      y = dy <<< PRE_SHIFT;
      z = 0;
      if (x < 0) begin
        // vector in the left half plane: rotate by pi first
        z = (y >= 0) ? longint'(PI16) : -longint'(PI16);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += ang_tab[i];
        end else begin
          x -= ys; y += xs; z -= ang_tab[i];
        end
      end
      if (x < 0) x = 0;
      r = (x * longint'(INV_GAIN16) + (64'sd1 <<< 29)) >>> 30;
    end
    if (r < longint'(arrive)) begin
      c.status = 1'b1;
      return c;
    end
    alpha = z - head * 8;
    if (alpha > longint'(PI16)) alpha -= longint'(TWO_PI16);
    else if (alpha < -longint'(PI16)) alpha += longint'(TWO_PI16);
    alpha = (alpha + 4) >>> 3;
    if (alpha > longint'(SIXTH_PI13) || alpha < -longint'(SIXTH_PI13)) begin
      c.turn = (alpha > 0) ? SIXTH_PI13 : -SIXTH_PI13;
    end else begin
      v = (longint'(speed_k) * r + 128) >>> 8;
      if (v > longint'(speed_lim)) v = longint'(speed_lim);
      c.speed = v[15:0];
      rot = (longint'(turn_k) * alpha + 128) >>> 8;
      if (rot > 32767) rot = 32767;
      if (rot < -32768) rot = -32768;
      c.turn = rot[15:0];
    end
    return c;
  endfunction

  assign pending = cmd_q.size();

  always @(posedge clk) begin
    command_t want, got;
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
      arrive <= 15'd26;
      speed_k <= 16'd256;
      turn_k <= 16'd256;
      speed_lim <= 15'd256;
      fails <= 0;
      cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GOAL_X:      goal_x <= cfg_data;
          REG_GOAL_Y:      goal_y <= cfg_data;
          REG_ARRIVE:      arrive <= cfg_data[14:0];
          REG_SPEED_GAIN:  speed_k <= cfg_data;
          REG_TURN_GAIN:   turn_k <= cfg_data;
          REG_SPEED_LIMIT: speed_lim <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) cmd_q.push_back(steer(s_tdata));
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[0];
        got.speed = m_tdata[16:1];
        got.turn = m_tdata[32:17];
        if (cmd_q.size() == 0) begin
          if (fails < 10) $display("unexpected result word %h", m_tdata);
          fails <= fails + 1;
        end else begin
          want = cmd_q.pop_front();
          if (want != got || m_tdata[39:33] != 7'd0) begin
            if (fails < 10)
              $display("mismatch: expected st=%0d spd=%0d turn=%0d, got st=%0d spd=%0d turn=%0d",
                       want.status, want.speed, want.turn, got.status, got.speed, got.turn);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/go_to_goal_steering_test.sv
// Stimulus and verdict for the go-to-goal steering block.
`timescale 1ns / 1ps
module go_to_goal_steering_test;
  import gtg_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [47:0] s_tdata;
  logic [39:0] m_tdata;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  int pending, fails;
  bit calm, hold_req;
  logic signed [15:0] gx, gy;

  go_to_goal_steering dut (.*);

  go_to_goal_steering_check chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .fails
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("go_to_goal_steering_test NOT OK");
    $finish;
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic put_pose(input logic [15:0] px, input logic [15:0] py, input logic [15:0] hd);
    bit ok;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {hd, py, px};
    forever begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  task automatic set_reg(input reg_index_t idx, input logic [15:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
    end
    cfg_valid <= 1'b0;
    if (idx == REG_GOAL_X) gx = val;
    if (idx == REG_GOAL_Y) gy = val;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] pick(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return lo[15:0];
      1: return hi[15:0];
      default: return 16'($urandom_range(hi - lo) + lo);
    endcase
  endfunction

  initial begin
    logic [15:0] px, py;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    hold_req = 0;
    gx = 0;
    gy = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: on goal, near goal, each axis, negative x side, extremes
    put_pose(16'd0, 16'd0, 16'd0);
    put_pose(16'd10, 16'd5, 16'd0);
    put_pose(16'hFF00, 16'd0, 16'd0);          // goal straight ahead along +x
    put_pose(16'd256, 16'd0, 16'd0);           // bearing pi
    put_pose(16'd256, 16'hFF00, 16'd0);        // dy >= 0 on the negative x side
    put_pose(16'd256, 16'd256, 16'd0);         // dy < 0 on the negative x side
    put_pose(16'hFF00, 16'd10, 16'd100);       // small heading error
    put_pose(16'h8000, 16'h8000, 16'h7FFF);
    put_pose(16'h7FFF, 16'h7FFF, 16'h8000);
    put_pose(16'h7FFF, 16'h8000, 16'hFFFF);
    put_pose(16'h8000, 16'h7FFF, 16'h0001);
    drain();

    // zero arrive distance: pose on the goal steers by heading alone
    set_reg(REG_ARRIVE, 16'd0);
    set_reg(reg_index_t'(3'd6), 16'hFFFF);     // unused index, ignored
    set_reg(reg_index_t'(3'd7), 16'h0000);
    put_pose(16'd0, 16'd0, 16'd0);
    put_pose(16'd0, 16'd0, 16'd100);
    put_pose(16'd0, 16'd0, 16'h8000);
    put_pose(16'd0, 16'd0, 16'h7FFF);
    drain();

    // extreme registers: saturated gains and caps
    set_reg(REG_GOAL_X, 16'h7FFF);
    set_reg(REG_GOAL_Y, 16'h8000);
    set_reg(REG_SPEED_GAIN, 16'hFFFF);
    set_reg(REG_TURN_GAIN, 16'hFFFF);
    set_reg(REG_SPEED_LIMIT, 16'h7FFF);
    put_pose(16'h8000, 16'h7FFF, 16'h0000);
    put_pose(16'h8000, 16'h7FFF, 16'hF300);
    put_pose(16'h7F00, 16'h8000, 16'h0000);
    put_pose(16'h0000, 16'h0000, 16'hFAC0);
    drain();
    set_reg(REG_ARRIVE, 16'h7FFF);
    put_pose(16'h0000, 16'h0000, 16'h0000);
    put_pose(16'h7FFF, 16'h8000, 16'h0000);
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) calm = 1;
      set_reg(REG_GOAL_X, pick(-32768, 32767));
      set_reg(REG_GOAL_Y, pick(-32768, 32767));
      set_reg(REG_ARRIVE, ($urandom_range(0, 7) == 0) ? pick(0, 32767) : pick(0, 1500));
      set_reg(REG_SPEED_GAIN, pick(0, 65535));
      set_reg(REG_TURN_GAIN, pick(0, 65535));
      set_reg(REG_SPEED_LIMIT, pick(0, 32767));
      for (int n = 0; n < 62; n++) begin
        if (ph == 4 && n == 5) hold_req = 1;
        case ($urandom_range(0, 9))
          0, 1: begin
            px = gx + 16'($signed($urandom_range(0, 1200)) - 600);
            py = gy + 16'($signed($urandom_range(0, 1200)) - 600);
          end
          2: begin
            px = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            py = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          end
          default: begin
            px = 16'($urandom);
            py = 16'($urandom);
          end
        endcase
        put_pose(px, py, 16'($urandom));
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("go_to_goal_steering_test OK");
    else
      $display("go_to_goal_steering_test NOT OK");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/gtg_pkg.sv
sv/gtg_cordic_stage.sv
sv/gtg_cordic.sv
sv/gtg_command.sv
sv/go_to_goal_steering.sv
sv/gtg_checker.sv
tb/go_to_goal_steering_check.sv
tb/go_to_goal_steering_test.sv
